### hdl/lffp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables of the laser frame file parser.
package lffp_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int RAINBOW_SIZE      = 64;

    // Section formats
    localparam logic [2:0] FMT_3D_INDEXED = 3'd0;
    localparam logic [2:0] FMT_2D_INDEXED = 3'd1;
    localparam logic [2:0] FMT_PALETTE    = 3'd2;
    localparam logic [2:0] FMT_3D_TRUE    = 3'd4;
    localparam logic [2:0] FMT_2D_TRUE    = 3'd5;

    typedef enum logic [1:0] {
        KIND_DOT        = 2'd0,
        KIND_BAD_MAGIC  = 2'd1,
        KIND_BAD_FORMAT = 2'd2,
        KIND_END        = 2'd3
    } lffp_kind_t;

    // Work handed from the byte parser to the dot stage, one per transfer
    typedef struct packed {
        logic        emit;
        lffp_kind_t  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [23:0] rgb_direct;
        logic        use_palette;
        logic        idx_oor;
        logic        blank;
        logic [15:0] frame;
        logic        finished;
        logic        box_clear;
        logic        box_update;
    } lffp_req_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h49;
            2'd1:    r = 8'h4C;
            2'd2:    r = 8'h44;
            default: r = 8'h41;
        endcase
        return r;
    endfunction

    function automatic logic format_ok(input logic [7:0] f);
        return f == 8'(FMT_3D_INDEXED) || f == 8'(FMT_2D_INDEXED) || f == 8'(FMT_PALETTE) ||
               f == 8'(FMT_3D_TRUE) || f == 8'(FMT_2D_TRUE);
    endfunction

    function automatic logic [3:0] record_width(input logic [2:0] f);
        logic [3:0] r;
        case (f)
            FMT_2D_INDEXED: r = 4'd6;
            FMT_PALETTE:    r = 4'd3;
            FMT_3D_TRUE:    r = 4'd10;
            default:        r = 4'd8;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] rainbow(input logic [5:0] idx);
        logic [23:0] r;
        case (idx)
            6'd0:  r = 24'hFF0000; 6'd1:  r = 24'hFF1000; 6'd2:  r = 24'hFF2000;
            6'd3:  r = 24'hFF3000; 6'd4:  r = 24'hFF4000; 6'd5:  r = 24'hFF5000;
            6'd6:  r = 24'hFF6000; 6'd7:  r = 24'hFF7000; 6'd8:  r = 24'hFF8000;
            6'd9:  r = 24'hFF9000; 6'd10: r = 24'hFFA000; 6'd11: r = 24'hFFB000;
            6'd12: r = 24'hFFC000; 6'd13: r = 24'hFFD000; 6'd14: r = 24'hFFE000;
            6'd15: r = 24'hFFF000; 6'd16: r = 24'hFFFF00; 6'd17: r = 24'hE0FF00;
            6'd18: r = 24'hC0FF00; 6'd19: r = 24'hA0FF00; 6'd20: r = 24'h80FF00;
            6'd21: r = 24'h60FF00; 6'd22: r = 24'h40FF00; 6'd23: r = 24'h20FF00;
            6'd24: r = 24'h00FF00; 6'd25: r = 24'h00FF24; 6'd26: r = 24'h00FF49;
            6'd27: r = 24'h00FF6D; 6'd28: r = 24'h00FF92; 6'd29: r = 24'h00FFB6;
            6'd30: r = 24'h00FFDB; 6'd31: r = 24'h00FFFF; 6'd32: r = 24'h00E3FF;
            6'd33: r = 24'h00C6FF; 6'd34: r = 24'h00AAFF; 6'd35: r = 24'h008EFF;
            6'd36: r = 24'h0071FF; 6'd37: r = 24'h0055FF; 6'd38: r = 24'h0038FF;
            6'd39: r = 24'h001CFF; 6'd40: r = 24'h0000FF; 6'd41: r = 24'h2000FF;
            6'd42: r = 24'h4000FF; 6'd43: r = 24'h6000FF; 6'd44: r = 24'h8000FF;
            6'd45: r = 24'hA000FF; 6'd46: r = 24'hC000FF; 6'd47: r = 24'hE000FF;
            6'd48: r = 24'hFF00FF; 6'd49: r = 24'hFF20FF; 6'd50: r = 24'hFF40FF;
            6'd51: r = 24'hFF60FF; 6'd52: r = 24'hFF80FF; 6'd53: r = 24'hFFA0FF;
            6'd54: r = 24'hFFC0FF; 6'd55: r = 24'hFFE0FF; 6'd56: r = 24'hFFFFFF;
            6'd57: r = 24'hFFE0E0; 6'd58: r = 24'hFFC0C0; 6'd59: r = 24'hFFA0A0;
            6'd60: r = 24'hFF8080; 6'd61: r = 24'hFF6060; 6'd62: r = 24'hFF4040;
            default: r = 24'hFF2020;
        endcase
        return r;
    endfunction

endpackage

### hdl/lffp_palette_ram.sv
`timescale 1ns / 1ps
// Palette store: synchronous RAM with per-entry valid bits over the rainbow reset table.
module lffp_palette_ram import lffp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int AW = $clog2(PALETTE_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [23:0]   rd_rgb
);

    logic [23:0]              mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg;
    logic [23:0]              rd_data_reg;
    logic                     rd_valid_reg;
    logic [AW-1:0]            rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Unwritten entries read as the reset table: the rainbow below RAINBOW_SIZE, zero from there up
    always_comb begin
        if (rd_valid_reg) begin
            rd_rgb = rd_data_reg;
        end else if (9'(rd_addr_reg) < 9'(RAINBOW_SIZE)) begin
            rd_rgb = rainbow(rd_addr_reg[5:0]);
        end else begin
            rd_rgb = '0;
        end
    end

endmodule

### hdl/lffp_byte_parser.sv
`timescale 1ns / 1ps
// Byte parser: header checks, record capture and palette writes.
module lffp_byte_parser import lffp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int AW = $clog2(PALETTE_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    file_byte,
    input  logic          start_of_file,
    output logic          pal_clear,
    output logic          pal_wr_en,
    output logic [AW-1:0] pal_wr_addr,
    output logic [23:0]   pal_wr_data,
    output logic [AW-1:0] pal_rd_addr,
    output lffp_req_t     req
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_RECORDS = 3'b010,
        PH_STOPPED = 3'b100
    } lffp_phase_t;

    localparam logic [4:0] HDR_FORMAT    = 5'd7;
    localparam logic [4:0] HDR_COUNT_HI  = 5'd24;
    localparam logic [4:0] HDR_COUNT_LO  = 5'd25;
    localparam logic [4:0] HDR_FRAME_HI  = 5'd26;
    localparam logic [4:0] HDR_FRAME_LO  = 5'd27;
    localparam logic [4:0] HDR_TOTAL_HI  = 5'd28;
    localparam logic [4:0] HDR_TOTAL_LO  = 5'd29;
    localparam logic [4:0] HDR_LAST      = 5'd31;
    localparam logic [4:0] MAGIC_LEN     = 5'd4;
    localparam logic [8:0] DEPTH_LIMIT   = 9'(PALETTE_DEPTH);
    localparam logic [8:0] FILL_RESET    = 9'(RAINBOW_SIZE);

    lffp_phase_t phase_reg, phase_c, phase_next;
    logic [4:0]  pos_reg, pos_c, pos_next;
    logic [2:0]  fmt_reg, fmt_c, fmt_next;
    logic [15:0] rec_reg, rec_c, rec_next;
    logic [15:0] frame_reg, frame_c, frame_next;
    logic [15:0] total_reg, total_c, total_next;
    logic [31:0] coord_reg, coord_c, coord_next;
    logic        blank_reg, blank_c, blank_next;
    logic [23:0] colour_reg, colour_c, colour_next;
    logic [8:0]  fill_reg, fill_c, fill_next;
    logic [4:0]  spos;
    logic [15:0] rec_dec;
    logic        last, ends;

    assign pal_clear   = accept && start_of_file;
    assign pal_rd_addr = file_byte[AW-1:0];

    always_comb begin
        // A new file starts from the reset state
        phase_c  = start_of_file ? PH_HEADER : phase_reg;
        pos_c    = start_of_file ? '0 : pos_reg;
        fmt_c    = start_of_file ? '0 : fmt_reg;
        rec_c    = start_of_file ? '0 : rec_reg;
        frame_c  = start_of_file ? '0 : frame_reg;
        total_c  = start_of_file ? '0 : total_reg;
        coord_c  = start_of_file ? '0 : coord_reg;
        blank_c  = start_of_file ? 1'b0 : blank_reg;
        colour_c = start_of_file ? '0 : colour_reg;
        fill_c   = start_of_file ? FILL_RESET : fill_reg;

        phase_next  = phase_c;
        pos_next    = pos_c;
        fmt_next    = fmt_c;
        rec_next    = rec_c;
        frame_next  = frame_c;
        total_next  = total_c;
        coord_next  = coord_c;
        blank_next  = blank_c;
        colour_next = colour_c;
        fill_next   = fill_c;

        pal_wr_en   = 1'b0;
        pal_wr_addr = fill_c[AW-1:0];
        pal_wr_data = '0;

        req           = '0;
        req.kind      = KIND_DOT;
        req.box_clear = start_of_file;
        req.idx_oor   = {1'b0, file_byte} >= DEPTH_LIMIT;

        spos    = (fmt_c == FMT_3D_INDEXED || fmt_c == FMT_3D_TRUE) ? 5'd6 : 5'd4;
        rec_dec = rec_c - 16'd1;
        last    = rec_dec == '0;
        ends    = last && !(({1'b0, frame_c} + 17'd1) < {1'b0, total_c});

        case (phase_c)
            PH_HEADER: begin
                if (pos_c < MAGIC_LEN && file_byte != magic_byte(pos_c[1:0])) begin
                    phase_next = PH_STOPPED;
                    req.emit   = 1'b1;
                    req.kind   = KIND_BAD_MAGIC;
                end else if (pos_c == HDR_FORMAT && !format_ok(file_byte)) begin
                    phase_next = PH_STOPPED;
                    req.emit   = 1'b1;
                    req.kind   = KIND_BAD_FORMAT;
                end else begin
                    case (pos_c)
                        HDR_FORMAT:   fmt_next          = file_byte[2:0];
                        HDR_COUNT_HI: rec_next[15:8]    = file_byte;
                        HDR_COUNT_LO: rec_next[7:0]     = file_byte;
                        HDR_FRAME_HI: frame_next[15:8]  = file_byte;
                        HDR_FRAME_LO: frame_next[7:0]   = file_byte;
                        HDR_TOTAL_HI: total_next[15:8]  = file_byte;
                        HDR_TOTAL_LO: total_next[7:0]   = file_byte;
                        default: ;
                    endcase
                    if (pos_c != HDR_LAST) begin
                        pos_next = pos_c + 5'd1;
                    end else begin
                        pos_next = '0;
                        // A palette header restarts filling at entry 0
                        if (fmt_c == FMT_PALETTE) begin
                            fill_next = '0;
                        end
                        if (rec_c == '0) begin
                            phase_next   = PH_STOPPED;
                            req.emit     = 1'b1;
                            req.kind     = KIND_END;
                            req.frame    = frame_c;
                            req.finished = 1'b1;
                        end else begin
                            phase_next = PH_RECORDS;
                        end
                    end
                end
            end
            PH_RECORDS: begin
                if (fmt_c == FMT_PALETTE) begin
                    colour_next = {colour_c[15:0], file_byte};
                end else begin
                    if (pos_c < MAGIC_LEN) begin
                        coord_next = {coord_c[23:0], file_byte};
                    end
                    if (pos_c == spos) begin
                        blank_next = file_byte[6];
                    end
                    if (fmt_c == FMT_3D_INDEXED || fmt_c == FMT_2D_INDEXED) begin
                        if (pos_c == spos + 5'd1) begin
                            colour_next = {16'h0000, file_byte};
                        end
                    end else begin
                        if (pos_c == spos + 5'd1) colour_next[7:0]   = file_byte;
                        if (pos_c == spos + 5'd2) colour_next[15:8]  = file_byte;
                        if (pos_c == spos + 5'd3) colour_next[23:16] = file_byte;
                    end
                end

                if (pos_c + 5'd1 < {1'b0, record_width(fmt_c)}) begin
                    pos_next = pos_c + 5'd1;
                end else begin
                    pos_next = '0;
                    rec_next = rec_dec;
                    if (last) begin
                        phase_next = ends ? PH_STOPPED : PH_HEADER;
                    end
                    if (fmt_c == FMT_PALETTE) begin
                        // Drop writes past the end of the store
                        if (fill_c < DEPTH_LIMIT) begin
                            pal_wr_en   = 1'b1;
                            pal_wr_data = colour_next;
                            fill_next   = fill_c + 9'd1;
                        end
                        if (ends) begin
                            req.emit     = 1'b1;
                            req.kind     = KIND_END;
                            req.frame    = frame_c;
                            req.finished = 1'b1;
                        end
                    end else begin
                        req.emit        = 1'b1;
                        req.kind        = KIND_DOT;
                        req.x           = coord_next[31:16] ^ 16'h8000;
                        req.y           = 16'h7FFF - coord_next[15:0];
                        req.use_palette = fmt_c == FMT_3D_INDEXED || fmt_c == FMT_2D_INDEXED;
                        req.rgb_direct  = colour_next;
                        req.blank       = blank_next;
                        req.frame       = frame_c;
                        req.finished    = ends;
                        req.box_update  = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        pal_wr_en = pal_wr_en && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            fmt_reg    <= '0;
            rec_reg    <= '0;
            frame_reg  <= '0;
            total_reg  <= '0;
            coord_reg  <= '0;
            blank_reg  <= 1'b0;
            colour_reg <= '0;
            fill_reg   <= FILL_RESET;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            fmt_reg    <= fmt_next;
            rec_reg    <= rec_next;
            frame_reg  <= frame_next;
            total_reg  <= total_next;
            coord_reg  <= coord_next;
            blank_reg  <= blank_next;
            colour_reg <= colour_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### hdl/lffp_dot_stage.sv
`timescale 1ns / 1ps
// Dot stage: colour resolution, bounding box and the output register.
module lffp_dot_stage import lffp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  lffp_req_t   req_in,
    input  logic [23:0] pal_rgb,
    output logic        advance,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_dot_x,
    output logic [15:0] m_dot_y,
    output logic [7:0]  m_dot_red,
    output logic [7:0]  m_dot_green,
    output logic [7:0]  m_dot_blue,
    output logic [15:0] m_frame_number,
    output logic [15:0] m_box_x_min,
    output logic [15:0] m_box_x_max,
    output logic [15:0] m_box_y_min,
    output logic [15:0] m_box_y_max,
    output logic        m_file_finished
);

    typedef struct packed {
        logic [15:0] x_min;
        logic [15:0] x_max;
        logic [15:0] y_min;
        logic [15:0] y_max;
    } lffp_box_t;

    localparam lffp_box_t BOX_RESET = '{x_min: 16'hFFFF, x_max: 16'h0000,
                                        y_min: 16'hFFFF, y_max: 16'h0000};

    logic        s2_valid_reg;
    lffp_req_t   req_reg;
    lffp_box_t   box_reg, box_base, box_next;
    logic [23:0] rgb;
    logic        load;

    logic        m_valid_reg;
    lffp_kind_t  kind_reg;
    logic [15:0] x_reg, y_reg, frame_reg;
    logic [23:0] rgb_reg;
    lffp_box_t   obox_reg;
    logic        finished_reg;

    // Hold the stage while a result waits here and the output register cannot drain
    assign advance = !(s2_valid_reg && req_reg.emit && m_valid_reg && !m_ready);
    assign load    = advance && s2_valid_reg && req_reg.emit;

    always_comb begin
        if (req_reg.blank) begin
            rgb = '0;
        end else if (req_reg.use_palette) begin
            rgb = req_reg.idx_oor ? 24'h000000 : pal_rgb;
        end else begin
            rgb = req_reg.rgb_direct;
        end

        box_base = req_reg.box_clear ? BOX_RESET : box_reg;
        box_next = box_base;
        if (req_reg.box_update) begin
            if (req_reg.x < box_base.x_min) box_next.x_min = req_reg.x;
            if (req_reg.x > box_base.x_max) box_next.x_max = req_reg.x;
            if (req_reg.y < box_base.y_min) box_next.y_min = req_reg.y;
            if (req_reg.y > box_base.y_max) box_next.y_max = req_reg.y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            box_reg      <= BOX_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                s2_valid_reg <= in_accept;
                if (s2_valid_reg) begin
                    box_reg <= box_next;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            req_reg <= req_in;
        end
        if (load) begin
            kind_reg     <= req_reg.kind;
            x_reg        <= req_reg.x;
            y_reg        <= req_reg.y;
            rgb_reg      <= rgb;
            frame_reg    <= req_reg.frame;
            obox_reg     <= box_next;
            finished_reg <= req_reg.finished;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_dot_x         = x_reg;
    assign m_dot_y         = y_reg;
    assign m_dot_red       = rgb_reg[23:16];
    assign m_dot_green     = rgb_reg[15:8];
    assign m_dot_blue      = rgb_reg[7:0];
    assign m_frame_number  = frame_reg;
    assign m_box_x_min     = obox_reg.x_min;
    assign m_box_x_max     = obox_reg.x_max;
    assign m_box_y_min     = obox_reg.y_min;
    assign m_box_y_max     = obox_reg.y_max;
    assign m_file_finished = finished_reg;

endmodule

### hdl/laser_frame_file_parser.sv
`timescale 1ns / 1ps
// Top level of the laser frame file parser: byte parser, palette store and dot stage.
//
// Usage: feed the file on the s_ channel, one byte per transfer, with
// s_start_of_file high on the first byte of each file. Results leave on the
// m_ channel: a dot per point record, or an error or end-of-file marker.
// Pipeline: two register stages (palette RAM read, output register); a byte's
// request and palette read are registered in the dot stage, then its result
// is loaded into the output register that drives m_valid.
// Throughput: one byte per cycle. With m_ready held high s_ready never drops,
// even when results come from consecutive bytes.
// Stalls: while m_ready is low the output register holds its result; the
// next result waits in the dot stage and s_ready falls until the output
// register drains, so nothing is lost.
// Reset (aresetn low, synchronous) and s_start_of_file both return the parse
// to the first header byte and the palette to its rainbow contents at once
// through per-entry valid bits; no clearing pass is needed.
// After a bad magic, a bad format or the end of the file, drop bytes until
// the next s_start_of_file.
module laser_frame_file_parser import lffp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int AW = $clog2(PALETTE_DEPTH)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_dot_x,
    output logic [15:0] m_dot_y,
    output logic [7:0]  m_dot_red,
    output logic [7:0]  m_dot_green,
    output logic [7:0]  m_dot_blue,
    output logic [15:0] m_frame_number,
    output logic [15:0] m_box_x_min,
    output logic [15:0] m_box_x_max,
    output logic [15:0] m_box_y_min,
    output logic [15:0] m_box_y_max,
    output logic        m_file_finished
);

    logic          advance;
    logic          accept;
    logic          pal_clear;
    logic          pal_wr_en;
    logic [AW-1:0] pal_wr_addr;
    logic [23:0]   pal_wr_data;
    logic [AW-1:0] pal_rd_addr;
    logic [23:0]   pal_rgb;
    lffp_req_t     req;

    // Take a byte whenever the dot stage can move on
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    lffp_byte_parser #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .file_byte     (s_file_byte),
        .start_of_file (s_start_of_file),
        .pal_clear     (pal_clear),
        .pal_wr_en     (pal_wr_en),
        .pal_wr_addr   (pal_wr_addr),
        .pal_wr_data   (pal_wr_data),
        .pal_rd_addr   (pal_rd_addr),
        .req           (req)
    );

    // Read the palette alongside every byte; the index byte of an indexed
    // record is its last byte, so the colour lines up with the dot stage.
    lffp_palette_ram #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (pal_clear),
        .wr_en   (pal_wr_en),
        .wr_addr (pal_wr_addr),
        .wr_data (pal_wr_data),
        .rd_en   (advance),
        .rd_addr (pal_rd_addr),
        .rd_rgb  (pal_rgb)
    );

    lffp_dot_stage u_dot (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (accept),
        .req_in          (req),
        .pal_rgb         (pal_rgb),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_dot_x         (m_dot_x),
        .m_dot_y         (m_dot_y),
        .m_dot_red       (m_dot_red),
        .m_dot_green     (m_dot_green),
        .m_dot_blue      (m_dot_blue),
        .m_frame_number  (m_frame_number),
        .m_box_x_min     (m_box_x_min),
        .m_box_x_max     (m_box_x_max),
        .m_box_y_min     (m_box_y_min),
        .m_box_y_max     (m_box_y_max),
        .m_file_finished (m_file_finished)
    );

endmodule

### verif/lffp_tb_pkg.sv
`timescale 1ns / 1ps
// Byte-level parse mirror and result ledger for the laser frame file parser bench.
package lffp_tb_pkg;
    import lffp_pkg::*;

    localparam int MIRROR_DEPTH = 256;
    localparam logic [7:0] BLANK_BIT = 8'h40;
    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h49, 8'h4C, 8'h44, 8'h41};

    // Header byte offsets
    localparam int POS_FORMAT   = 7;
    localparam int POS_RECS_HI  = 24;
    localparam int POS_RECS_LO  = 25;
    localparam int POS_FRAME_HI = 26;
    localparam int POS_FRAME_LO = 27;
    localparam int POS_TOTAL_HI = 28;
    localparam int POS_TOTAL_LO = 29;
    localparam int POS_LAST     = 31;

    localparam logic [23:0] RAINBOW_TABLE [64] = '{
        24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000, 24'hFF4000, 24'hFF5000, 24'hFF6000,
        24'hFF7000, 24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000, 24'hFFC000, 24'hFFD000,
        24'hFFE000, 24'hFFF000, 24'hFFFF00, 24'hE0FF00, 24'hC0FF00, 24'hA0FF00, 24'h80FF00,
        24'h60FF00, 24'h40FF00, 24'h20FF00, 24'h00FF00, 24'h00FF24, 24'h00FF49, 24'h00FF6D,
        24'h00FF92, 24'h00FFB6, 24'h00FFDB, 24'h00FFFF, 24'h00E3FF, 24'h00C6FF, 24'h00AAFF,
        24'h008EFF, 24'h0071FF, 24'h0055FF, 24'h0038FF, 24'h001CFF, 24'h0000FF, 24'h2000FF,
        24'h4000FF, 24'h6000FF, 24'h8000FF, 24'hA000FF, 24'hC000FF, 24'hE000FF, 24'hFF00FF,
        24'hFF20FF, 24'hFF40FF, 24'hFF60FF, 24'hFF80FF, 24'hFFA0FF, 24'hFFC0FF, 24'hFFE0FF,
        24'hFFFFFF, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0, 24'hFF8080, 24'hFF6060, 24'hFF4040,
        24'hFF2020
    };

    typedef enum logic [1:0] {IN_HEADER, IN_RECORDS, HALTED} parse_phase_e;

    typedef struct {
        lffp_kind_t  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] frame;
        logic [15:0] x_min;
        logic [15:0] x_max;
        logic [15:0] y_min;
        logic [15:0] y_max;
        logic        finished;
    } dot_result_t;

    function automatic bit format_known(logic [7:0] f);
        return f == 8'(FMT_3D_INDEXED) || f == 8'(FMT_2D_INDEXED) || f == 8'(FMT_PALETTE)
            || f == 8'(FMT_3D_TRUE) || f == 8'(FMT_2D_TRUE);
    endfunction

    function automatic int record_bytes(logic [2:0] f);
        case (f)
            FMT_2D_INDEXED: return 6;
            FMT_PALETTE:    return 3;
            FMT_3D_TRUE:    return 10;
            default:        return 8;
        endcase
    endfunction

    class dot_ledger;
        dot_result_t  dots_owed[$];
        int           errors;
        int           bytes_parsed;
        int           seen_dots;
        int           seen_bad_magic;
        int           seen_bad_format;
        int           seen_ends;

        logic [23:0]  pal [MIRROR_DEPTH];
        logic [8:0]   pal_fill;
        parse_phase_e phase;
        logic [4:0]   pos;
        logic [2:0]   fmt;
        logic [15:0]  recs_left;
        logic [15:0]  frame;
        logic [15:0]  total;
        logic [31:0]  coord;
        logic [7:0]   status;
        logic [23:0]  colour;
        logic [15:0]  x_lo, x_hi, y_lo, y_hi;

        function new();
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < MIRROR_DEPTH; i++)
                pal[i] = (i < 64) ? RAINBOW_TABLE[i] : 24'h0;
            pal_fill  = 9'd64;
            phase     = IN_HEADER;
            pos       = '0;
            fmt       = '0;
            recs_left = '0;
            frame     = '0;
            total     = '0;
            coord     = '0;
            status    = '0;
            colour    = '0;
            x_lo      = 16'hFFFF;
            x_hi      = '0;
            y_lo      = 16'hFFFF;
            y_hi      = '0;
        endfunction

        function dot_result_t outcome(lffp_kind_t kind, logic [15:0] x, logic [15:0] y,
                                      logic [23:0] rgb, logic [15:0] fr, logic fin);
            dot_result_t r;
            r.kind     = kind;
            r.x        = x;
            r.y        = y;
            r.red      = rgb[23:16];
            r.green    = rgb[15:8];
            r.blue     = rgb[7:0];
            r.frame    = fr;
            r.x_min    = x_lo;
            r.x_max    = x_hi;
            r.y_min    = y_lo;
            r.y_max    = y_hi;
            r.finished = fin;
            return r;
        endfunction

        // Parse one byte; return 1 when it yields a result.
        function bit parse_byte(logic [7:0] b, output dot_result_t r);
            int          p;
            int          spos;
            bit          indexed;
            bit          last;
            bit          ends;
            logic [15:0] x;
            logic [15:0] y;
            logic [23:0] rgb;
            p = pos;
            if (phase == HALTED)
                return 0;
            if (phase == IN_HEADER) begin
                if (p < 4 && b != MAGIC_BYTES[p]) begin
                    phase = HALTED;
                    r = outcome(KIND_BAD_MAGIC, '0, '0, '0, '0, 1'b0);
                    return 1;
                end
                case (p)
                    POS_FORMAT: begin
                        if (!format_known(b)) begin
                            phase = HALTED;
                            r = outcome(KIND_BAD_FORMAT, '0, '0, '0, '0, 1'b0);
                            return 1;
                        end
                        fmt = b[2:0];
                    end
                    POS_RECS_HI:  recs_left[15:8] = b;
                    POS_RECS_LO:  recs_left[7:0]  = b;
                    POS_FRAME_HI: frame[15:8]     = b;
                    POS_FRAME_LO: frame[7:0]      = b;
                    POS_TOTAL_HI: total[15:8]     = b;
                    POS_TOTAL_LO: total[7:0]      = b;
                    default: ;
                endcase
                if (p < POS_LAST) begin
                    pos = 5'(p + 1);
                    return 0;
                end
                pos = '0;
                if (fmt == FMT_PALETTE)
                    pal_fill = '0;
                if (recs_left == 16'd0) begin
                    phase = HALTED;
                    r = outcome(KIND_END, '0, '0, '0, frame, 1'b1);
                    return 1;
                end
                phase = IN_RECORDS;
                return 0;
            end

            indexed = (fmt == FMT_3D_INDEXED || fmt == FMT_2D_INDEXED);
            if (fmt == FMT_PALETTE) begin
                colour = {colour[15:0], b};
            end else begin
                if (p < 4)
                    coord = {coord[23:0], b};
                spos = (fmt == FMT_3D_INDEXED || fmt == FMT_3D_TRUE) ? 6 : 4;
                if (p == spos)
                    status = b;
                if (indexed) begin
                    if (p == spos + 1)
                        colour = {16'h0, b};
                end else begin
                    if (p == spos + 1) colour[7:0]   = b;
                    if (p == spos + 2) colour[15:8]  = b;
                    if (p == spos + 3) colour[23:16] = b;
                end
            end
            if (p + 1 < record_bytes(fmt)) begin
                pos = 5'(p + 1);
                return 0;
            end
            pos = '0;
            recs_left = recs_left - 16'd1;
            last = (recs_left == 16'd0);
            ends = last && !(({1'b0, frame} + 17'd1) < {1'b0, total});
            if (last)
                phase = ends ? HALTED : IN_HEADER;

            if (fmt == FMT_PALETTE) begin
                if (pal_fill < MIRROR_DEPTH) begin
                    pal[pal_fill[7:0]] = colour;
                    pal_fill = pal_fill + 9'd1;
                end
                if (ends) begin
                    r = outcome(KIND_END, '0, '0, '0, frame, 1'b1);
                    return 1;
                end
                return 0;
            end

            x   = coord[31:16] ^ 16'h8000;
            y   = 16'h7FFF - coord[15:0];
            rgb = indexed ? pal[colour[7:0]] : colour;
            if ((status & BLANK_BIT) != 8'h0)
                rgb = '0;
            if (x < x_lo) x_lo = x;
            if (x > x_hi) x_hi = x;
            if (y < y_lo) y_lo = y;
            if (y > y_hi) y_hi = y;
            r = outcome(KIND_DOT, x, y, rgb, frame, ends);
            return 1;
        endfunction

        function void note_byte(logic [7:0] b, logic sof);
            dot_result_t r;
            if (sof)
                restart();
            if (phase != HALTED)
                bytes_parsed++;
            if (parse_byte(b, r))
                dots_owed.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(dot_result_t got);
            dot_result_t want;
            if (dots_owed.size() == 0) begin
                $display("%0t: result with nothing expected, kind %0d x %0h y %0h",
                         $time, got.kind, got.x, got.y);
                errors++;
                return;
            end
            want = dots_owed.pop_front();
            case (want.kind)
                KIND_DOT:        seen_dots++;
                KIND_BAD_MAGIC:  seen_bad_magic++;
                KIND_BAD_FORMAT: seen_bad_format++;
                default:         seen_ends++;
            endcase
            compare("result_kind", want.kind, got.kind);
            compare("dot_x", want.x, got.x);
            compare("dot_y", want.y, got.y);
            compare("dot_red", want.red, got.red);
            compare("dot_green", want.green, got.green);
            compare("dot_blue", want.blue, got.blue);
            compare("frame_number", want.frame, got.frame);
            compare("box_x_min", want.x_min, got.x_min);
            compare("box_x_max", want.x_max, got.x_max);
            compare("box_y_min", want.y_min, got.y_min);
            compare("box_y_max", want.y_max, got.y_max);
            compare("file_finished", want.finished, got.finished);
        endfunction

        function int pending();
            return dots_owed.size();
        endfunction
    endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench of the laser frame file parser: stimulus, result sink and verdict.
module tb_top;
    import lffp_pkg::*;
    import lffp_tb_pkg::*;

    // Parsed bytes wanted from the random part; ignored bytes do not count
    localparam int RANDOM_BYTES  = 300;
    // Cycles to let the two-stage result pipe settle after the last transfer
    localparam int SETTLE_CYCLES = 8;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_file_byte     = 8'h00;
    logic        s_start_of_file = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [1:0]  m_result_kind;
    logic [15:0] m_dot_x;
    logic [15:0] m_dot_y;
    logic [7:0]  m_dot_red;
    logic [7:0]  m_dot_green;
    logic [7:0]  m_dot_blue;
    logic [15:0] m_frame_number;
    logic [15:0] m_box_x_min;
    logic [15:0] m_box_x_max;
    logic [15:0] m_box_y_min;
    logic [15:0] m_box_y_max;
    logic        m_file_finished;

    dot_ledger   ledger = new();
    logic [7:0]  file_image[$];
    bit          tx_quiet;
    int          files_sent;

    laser_frame_file_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_start_of_file (s_start_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_dot_x         (m_dot_x),
        .m_dot_y         (m_dot_y),
        .m_dot_red       (m_dot_red),
        .m_dot_green     (m_dot_green),
        .m_dot_blue      (m_dot_blue),
        .m_frame_number  (m_frame_number),
        .m_box_x_min     (m_box_x_min),
        .m_box_x_max     (m_box_x_max),
        .m_box_y_min     (m_box_y_min),
        .m_box_y_max     (m_box_y_max),
        .m_file_finished (m_file_finished)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hang guard: far beyond the slowest legal run of roughly thirteen hundred
    // bytes with the longest gaps and stalls on both sides.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short pauses, the odd long one.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int sender_gap();
        if (tx_quiet || $urandom_range(0, 99) < 55)
            return 0;
        return pause_length();
    endfunction

    // Result sink: outputs are read just after the edge, so they hold the
    // values the block presented at that edge; m_ready gets one update per edge.
    initial begin : result_sink
        dot_result_t got;
        int          stall_left;
        int          quiet_left;
        bit          rx_quiet;
        stall_left = 0;
        quiet_left = 0;
        rx_quiet   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind     = lffp_kind_t'(m_result_kind);
                got.x        = m_dot_x;
                got.y        = m_dot_y;
                got.red      = m_dot_red;
                got.green    = m_dot_green;
                got.blue     = m_dot_blue;
                got.frame    = m_frame_number;
                got.x_min    = m_box_x_min;
                got.x_max    = m_box_x_max;
                got.y_min    = m_box_y_min;
                got.y_max    = m_box_y_max;
                got.finished = m_file_finished;
                ledger.check_result(got);
            end
            // Alternate stretches of steady acceptance with stretches of stalls
            if (quiet_left > 0) begin
                quiet_left--;
            end else begin
                rx_quiet   = ($urandom_range(0, 3) == 0);
                quiet_left = $urandom_range(50, 300);
            end
            if (rx_quiet) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall_left = pause_length() - 1;
            end
        end
    end

    // Offer one byte, hold it until the transfer, then let the ledger parse it.
    // s_ready is read just after the edge, i.e. the value the block sampled.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_file_byte     <= b;
        s_start_of_file <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_byte(b, sof);
    endtask

    task automatic send_file();
        foreach (file_image[i])
            send_byte(file_image[i], i == 0);
        files_sent++;
    endtask

    // Hold the sender until every owed result has been checked.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (ledger.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void put_random(int count);
        repeat (count) file_image.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Coordinates: a quarter of them at the signed and unsigned extremes
    function automatic logic [15:0] coord_value();
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic void put_header(logic [7:0] fmt, logic [15:0] recs,
                                       logic [15:0] frame, logic [15:0] total);
        foreach (MAGIC_BYTES[i])
            file_image.push_back(MAGIC_BYTES[i]);
        put_random(3);
        file_image.push_back(fmt);
        put_random(16);
        file_image.push_back(recs[15:8]);
        file_image.push_back(recs[7:0]);
        file_image.push_back(frame[15:8]);
        file_image.push_back(frame[7:0]);
        file_image.push_back(total[15:8]);
        file_image.push_back(total[7:0]);
        put_random(2);
    endfunction

    function automatic void put_record(logic [2:0] fmt);
        logic [15:0] x;
        logic [15:0] y;
        int          width;
        width = record_bytes(fmt);
        if (fmt == FMT_PALETTE) begin
            put_random(width);
            return;
        end
        x = coord_value();
        y = coord_value();
        file_image.push_back(x[15:8]);
        file_image.push_back(x[7:0]);
        file_image.push_back(y[15:8]);
        file_image.push_back(y[7:0]);
        // For indexed formats the colour index is the final byte: push the
        // palette ends hard now and then
        if ((fmt == FMT_3D_INDEXED || fmt == FMT_2D_INDEXED) && $urandom_range(0, 3) == 0) begin
            put_random(width - 5);
            file_image.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        end else begin
            put_random(width - 4);
        end
    endfunction

    function automatic logic [2:0] pick_format();
        if ($urandom_range(0, 99) < 15)
            return FMT_PALETTE;
        case ($urandom_range(0, 3))
            0:       return FMT_3D_INDEXED;
            1:       return FMT_2D_INDEXED;
            2:       return FMT_3D_TRUE;
            default: return FMT_2D_TRUE;
        endcase
    endfunction

    // Well-formed file of one to four sections; frame numbers near the top of
    // their range and totals of zero or all ones turn up now and then.
    function automatic void build_good_file();
        int          sections;
        int          recs;
        int          r;
        logic [15:0] base;
        logic [15:0] total;
        logic [2:0]  f;
        sections = $urandom_range(1, 4);
        r = $urandom_range(0, 19);
        base  = (r == 0) ? 16'hFFFC : 16'($urandom_range(0, 200));
        total = base + 16'(sections);
        if (r == 1) total = 16'hFFFF;
        if (r == 2) total = 16'h0000;
        for (int s = 0; s < sections; s++) begin
            f = pick_format();
            if ($urandom_range(0, 14) == 0)
                recs = 0;
            else
                recs = (f == FMT_PALETTE) ? $urandom_range(1, 12) : $urandom_range(1, 6);
            put_header(8'(f), 16'(recs), base + 16'(s), total);
            repeat (recs) put_record(f);
            if (recs == 0)
                break;
        end
    endfunction

    initial begin : stimulus
        int         start_count;
        int         r;
        int         n;
        logic [7:0] w;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: bad magic at each of the four positions, the old
        // format 3, bytes after a stop, and a header cut short by a new file.
        tx_quiet = 1'b0;
        file_image = '{8'h58, 8'h00};
        send_file();
        file_image = '{MAGIC_BYTES[0], 8'h58};
        send_file();
        file_image = '{MAGIC_BYTES[0], MAGIC_BYTES[1], 8'h00};
        send_file();
        file_image = '{MAGIC_BYTES[0], MAGIC_BYTES[1], MAGIC_BYTES[2], 8'h61};
        send_file();
        file_image = '{MAGIC_BYTES[0], MAGIC_BYTES[1], MAGIC_BYTES[2], MAGIC_BYTES[3],
                       8'h00, 8'h00, 8'h00, 8'h03, 8'hFF};
        send_file();
        file_image = '{MAGIC_BYTES[0], MAGIC_BYTES[1]};
        send_file();
        hold_until_drained();

        // Palette overflow first: 258 colours into a 256-entry store, then
        // dots that index it, now and then at its top or bottom entry.
        file_image.delete();
        put_header(8'(FMT_PALETTE), 16'd258, 16'd0, 16'd2);
        repeat (258) put_record(FMT_PALETTE);
        put_header(8'(FMT_3D_INDEXED), 16'd8, 16'd1, 16'd2);
        repeat (8) put_record(FMT_3D_INDEXED);
        send_file();

        // Random part: mostly well-formed files, the rest broken on purpose
        start_count = ledger.bytes_parsed;
        while (ledger.bytes_parsed - start_count < RANDOM_BYTES) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            file_image.delete();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // bad magic at a random position, with trailing junk
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    file_image.push_back(MAGIC_BYTES[i]);
                do w = 8'($urandom_range(0, 255)); while (w == MAGIC_BYTES[n]);
                file_image.push_back(w);
                put_random($urandom_range(0, 4));
            end else if (r < 14) begin
                do w = 8'($urandom_range(0, 255)); while (format_known(w));
                put_header(w, 16'd1, 16'd0, 16'd1);
            end else if (r < 22) begin
                // truncate; the next start of file restarts the parse
                build_good_file();
                n = $urandom_range(1, file_image.size() - 1);
                file_image = file_image[0:n-1];
            end else begin
                build_good_file();
                if ($urandom_range(0, 4) == 0)
                    put_random($urandom_range(1, 3));
            end
            send_file();
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        tx_quiet = 1'b0;
        hold_until_drained();

        $display("Run summary: %0d files, %0d parsed bytes, %0d dots checked.",
                 files_sent, ledger.bytes_parsed, ledger.seen_dots);
        $display("Non-dot results: %0d bad magic, %0d bad format, %0d file ends.",
                 ledger.seen_bad_magic, ledger.seen_bad_format, ledger.seen_ends);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
